FILE: rtl/core/pst_pkg.sv
// Shared types and codes for the process state table.
// No dependencies; used by every module of the block.
package pst_pkg;

	typedef enum logic [3:0] {
		FN_ALLOC    = 4'd0,
		FN_RUNNABLE = 4'd1,
		FN_RUNNING  = 4'd2,
		FN_SLEEP    = 4'd3,
		FN_WAKEUP   = 4'd4,
		FN_KILL     = 4'd5,
		FN_EXIT     = 4'd6,
		FN_REAP     = 4'd7,
		FN_TICK     = 4'd8
	} func_t;

	typedef enum logic [2:0] {
		PS_UNUSED   = 3'd0,
		PS_EMBRYO   = 3'd1,
		PS_SLEEPING = 3'd2,
		PS_RUNNABLE = 3'd3,
		PS_RUNNING  = 3'd4,
		PS_ZOMBIE   = 3'd5
	} pstate_t;

	localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;
	localparam logic [15:0] PID_MAX = 16'hFFFF;
	localparam logic [6:0]  WOKE_MAX = 7'd127;

	typedef struct packed {
		logic [2:0]         state;
		logic [15:0]        pid;
		logic [31:0]        chan;
		logic               killed;
		logic signed [31:0] status;
		logic [31:0]        ready_cnt;
		logic [31:0]        run_cnt;
		logic [31:0]        sleep_cnt;
	} entry_t;

	typedef struct packed {
		logic [3:0]         func;
		logic [5:0]         slot;
		logic [15:0]        pid;
		logic [31:0]        chan;
		logic signed [31:0] exit_code;
	} req_t;

	typedef struct packed {
		logic               ok;
		logic [5:0]         slot_out;
		logic [15:0]        pid_out;
		logic signed [31:0] status_out;
		logic [31:0]        ready_ticks;
		logic [31:0]        run_ticks;
		logic [31:0]        sleep_ticks;
		logic [6:0]         woken_count;
	} rsp_t;

	// per-entry decision of the update logic
	typedef struct packed {
		logic wr;
		logic wvld;
		logic match;
		logic ok;
		logic woke;
	} upd_t;

endpackage

FILE: rtl/core/pst_table.sv
// Entry store: one synchronous memory, one read and one write port.
// Per-entry valid bits make unwritten entries read as cleared. Uses pst_pkg.
module pst_table import pst_pkg::*; #(
	parameter int SLOTS = 64,
	parameter int IW = $clog2(SLOTS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [IW-1:0] ra,
	input  logic          we,
	input  logic [IW-1:0] wa,
	input  entry_t        wd,
	input  logic          wvld,
	output entry_t        rd
);

	entry_t           mem [SLOTS];
	entry_t           rd_q;
	logic             rvld_q;
	logic [SLOTS-1:0] vld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[wa] <= wvld;
			end
			rvld_q <= vld_q[ra];
		end
	end

	assign rd = rvld_q ? rd_q : '0;

endmodule

FILE: rtl/core/pst_upd.sv
// Per-entry update: decides the new contents of one entry for an operation.
// Purely combinational; uses pst_pkg.
module pst_upd import pst_pkg::*; (
	input  req_t        req,
	input  logic        found,
	input  logic [15:0] next_pid,
	input  entry_t      cur,
	output entry_t      nxt,
	output upd_t        upd
);

	logic live;
	logic pid_hit;

	always_comb begin
		live = (cur.state == PS_EMBRYO) || (cur.state == PS_SLEEPING) ||
			(cur.state == PS_RUNNABLE) || (cur.state == PS_RUNNING);
		pid_hit = !found && (cur.state != PS_UNUSED) && (cur.pid == req.pid);
		nxt = cur;
		upd = '0;
		upd.wvld = 1'b1;
		case (req.func)
			FN_ALLOC: begin
				if (!found && cur.state == PS_UNUSED) begin
					nxt = '0;
					nxt.state = PS_EMBRYO;
					nxt.pid = next_pid;
					upd.wr = 1'b1;
					upd.match = 1'b1;
					upd.ok = 1'b1;
				end
			end
			FN_RUNNABLE, FN_RUNNING, FN_SLEEP, FN_EXIT: begin
				if (live) begin
					upd.wr = 1'b1;
					upd.ok = 1'b1;
					case (req.func)
						FN_RUNNABLE: nxt.state = PS_RUNNABLE;
						FN_RUNNING:  nxt.state = PS_RUNNING;
						FN_SLEEP: begin
							nxt.state = PS_SLEEPING;
							nxt.chan = req.chan;
						end
						default: begin
							nxt.state = PS_ZOMBIE;
							nxt.status = req.exit_code;
						end
					endcase
				end
			end
			FN_WAKEUP: begin
				if (cur.state == PS_SLEEPING && cur.chan == req.chan) begin
					nxt.state = PS_RUNNABLE;
					upd.wr = 1'b1;
					upd.woke = 1'b1;
				end
			end
			FN_KILL: begin
				if (pid_hit) begin
					nxt.killed = 1'b1;
					if (cur.state == PS_SLEEPING) begin
						nxt.state = PS_RUNNABLE;
					end
					upd.wr = 1'b1;
					upd.match = 1'b1;
					upd.ok = 1'b1;
				end
			end
			FN_REAP: begin
				if (pid_hit) begin
					upd.match = 1'b1;
					if (cur.state == PS_ZOMBIE) begin
						// free the entry: valid bit off reads back as cleared
						upd.wr = 1'b1;
						upd.wvld = 1'b0;
						upd.ok = 1'b1;
					end
				end
			end
			FN_TICK: begin
				case (cur.state)
					PS_RUNNABLE: begin
						upd.wr = 1'b1;
						if (cur.ready_cnt != CNT_MAX) nxt.ready_cnt = cur.ready_cnt + 32'd1;
					end
					PS_RUNNING: begin
						upd.wr = 1'b1;
						if (cur.run_cnt != CNT_MAX) nxt.run_cnt = cur.run_cnt + 32'd1;
					end
					PS_SLEEPING: begin
						upd.wr = 1'b1;
						if (cur.sleep_cnt != CNT_MAX) nxt.sleep_cnt = cur.sleep_cnt + 32'd1;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

endmodule

FILE: rtl/core/process_state_table_unit.sv
// Process state table: top level with sequencer and result register.
// Depends on pst_pkg, pst_table and pst_upd.
//
// Usage:
//   Request channel req_valid / req_stall / req carries one operation per
//   transaction. Response channel rsp_valid / rsp_stall / rsp returns
//   exactly one result per request, in order.
//   The block works on one request at a time. Single-slot operations
//   (runnable, running, sleep, exit) read and write only the addressed
//   entry; alloc, wakeup, kill, reap and tick walk every entry through the
//   one-read, one-write memory. Unknown codes and slots beyond the table
//   skip the table and go straight to the result.
//   req_stall is low only while no request is in progress; a new request
//   can be taken while the previous result still waits in the output
//   register. If rsp_stall holds the response, the finished request waits
//   for the register before the next one is accepted.
//   Reset clears all entries at once through per-entry valid bits and sets
//   the next pid to one; no clearing pass is needed.
module process_state_table_unit import pst_pkg::*; #(
	parameter int SLOTS = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FIN
	} fsm_t;

	fsm_t          state_q;
	req_t          req_q;
	logic [IW-1:0] cnt_q;
	logic [IW-1:0] last_q;
	logic          iss_q;
	logic          p_vld_s1;
	logic [IW-1:0] p_addr_s1;
	logic          found_q;
	logic          ok_q;
	logic [6:0]    woke_q;
	logic [15:0]   next_pid_q;
	rsp_t          res_q;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	entry_t        rd;
	entry_t        nxt;
	upd_t          upd;
	logic          we;
	logic          single;
	logic          in_range;
	logic          known;
	rsp_t          fin_rsp;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;
	assign we = p_vld_s1 && upd.wr;

	always_comb begin
		single = (req.func == FN_RUNNABLE) || (req.func == FN_RUNNING) ||
			(req.func == FN_SLEEP) || (req.func == FN_EXIT);
		known = single || (req.func == FN_ALLOC) || (req.func == FN_WAKEUP) ||
			(req.func == FN_KILL) || (req.func == FN_REAP) || (req.func == FN_TICK);
		in_range = !single || (int'(req.slot) < SLOTS);
	end

	always_comb begin
		fin_rsp = res_q;
		fin_rsp.ok = ok_q;
		fin_rsp.woken_count = woke_q;
	end

	pst_table #(.SLOTS(SLOTS), .IW(IW)) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.ra     (cnt_q),
		.we     (we),
		.wa     (p_addr_s1),
		.wd     (nxt),
		.wvld   (upd.wvld),
		.rd     (rd)
	);

	pst_upd u_upd (
		.req      (req_q),
		.found    (found_q),
		.next_pid (next_pid_q),
		.cur      (rd),
		.nxt      (nxt),
		.upd      (upd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			iss_q       <= 1'b0;
			p_vld_s1    <= 1'b0;
			found_q     <= 1'b0;
			ok_q        <= 1'b0;
			woke_q      <= '0;
			next_pid_q  <= 16'd1;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall && state_q != S_FIN) begin
				rsp_valid_q <= 1'b0;
			end
			p_vld_s1 <= (state_q == S_SCAN) && iss_q;
			p_addr_s1 <= cnt_q;
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						req_q   <= req;
						found_q <= 1'b0;
						ok_q    <= (req.func == FN_TICK);
						woke_q  <= '0;
						res_q   <= '0;
						cnt_q   <= single ? IW'(req.slot) : '0;
						last_q  <= single ? IW'(req.slot) : IW'(SLOTS - 1);
						iss_q   <= 1'b1;
						state_q <= (known && in_range) ? S_SCAN : S_FIN;
					end
				end
				S_SCAN: begin
					if (iss_q) begin
						if (cnt_q == last_q) begin
							iss_q <= 1'b0;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
					if (p_vld_s1) begin
						if (upd.match) begin
							found_q <= 1'b1;
						end
						if (upd.ok) begin
							ok_q <= 1'b1;
						end
						if (upd.woke) begin
							ok_q <= 1'b1;
							if (woke_q != WOKE_MAX) woke_q <= woke_q + 7'd1;
						end
						if (upd.ok && req_q.func == FN_ALLOC) begin
							res_q.slot_out <= 6'(p_addr_s1);
							res_q.pid_out  <= next_pid_q;
							next_pid_q <= (next_pid_q == PID_MAX) ? 16'd1 : next_pid_q + 16'd1;
						end
						if (upd.ok && req_q.func == FN_REAP) begin
							res_q.slot_out    <= 6'(p_addr_s1);
							res_q.pid_out     <= rd.pid;
							res_q.status_out  <= rd.status;
							res_q.ready_ticks <= rd.ready_cnt;
							res_q.run_ticks   <= rd.run_cnt;
							res_q.sleep_ticks <= rd.sleep_cnt;
						end
					end
					if (!iss_q && !p_vld_s1) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q <= fin_rsp;
						rsp_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// a write never lands on the entry being read in the same cycle
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(we && iss_q && state_q == S_SCAN) |-> (p_addr_s1 != cnt_q))
		else $error("write and read hit the same entry");

	a_pid_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		next_pid_q != 16'd0)
		else $error("next pid is zero");

	a_rsp_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == S_FIN))
		else $error("response raised outside finish");

	a_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> state_q == S_SCAN)
		else $error("table write outside a scan");
`endif

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for process_state_table_unit.
// Drives request transactions, predicts each result from a local task-table
// model and compares responses in order. Depends on pst_pkg.
`timescale 1ns / 1ps

module testbench;
	import pst_pkg::*;

	localparam int NSLOT = 64;
	localparam int N_RANDOM = 1300;
	localparam int CYCLE_LIMIT = 600000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	process_state_table_unit #(.SLOTS(NSLOT)) u_top (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow task table
	entry_t tbl [NSLOT];
	logic [15:0] pid_next;
	rsp_t expected_rsp [$];
	int err_count = 0;
	int rsp_count = 0;
	int cycles = 0;
	bit quiet = 1'b0;

	task automatic report(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("MISMATCH @%0t rsp %0d %s: got %h want %h", $realtime, rsp_count,
			what, got, want);
		err_count++;
	endtask

	function automatic logic [31:0] sat_add(input logic [31:0] v);
		return (v == CNT_MAX) ? v : v + 32'd1;
	endfunction

	function automatic bit live(input int i);
		return tbl[i].state inside {PS_EMBRYO, PS_SLEEPING, PS_RUNNABLE, PS_RUNNING};
	endfunction

	function automatic int find_pid(input logic [15:0] p);
		for (int i = 0; i < NSLOT; i++)
			if (tbl[i].state != PS_UNUSED && tbl[i].pid == p) return i;
		return -1;
	endfunction

	function automatic rsp_t table_step(input req_t r);
		rsp_t o;
		int k;
		int n;
		o = '0;
		n = 0;
		case (r.func)
			FN_ALLOC: begin
				k = -1;
				for (int i = 0; i < NSLOT && k < 0; i++)
					if (tbl[i].state == PS_UNUSED) k = i;
				if (k >= 0) begin
					tbl[k] = '0;
					tbl[k].state = PS_EMBRYO;
					tbl[k].pid = pid_next;
					o.ok = 1'b1;
					o.slot_out = 6'(k);
					o.pid_out = pid_next;
					pid_next = (pid_next == PID_MAX) ? 16'd1 : pid_next + 16'd1;
				end
			end
			FN_RUNNABLE, FN_RUNNING, FN_SLEEP, FN_EXIT: begin
				if (r.slot < NSLOT && live(r.slot)) begin
					case (r.func)
						FN_RUNNABLE: tbl[r.slot].state = PS_RUNNABLE;
						FN_RUNNING: tbl[r.slot].state = PS_RUNNING;
						FN_SLEEP: begin
							tbl[r.slot].chan = r.chan;
							tbl[r.slot].state = PS_SLEEPING;
						end
						default: begin
							tbl[r.slot].status = r.exit_code;
							tbl[r.slot].state = PS_ZOMBIE;
						end
					endcase
					o.ok = 1'b1;
				end
			end
			FN_WAKEUP: begin
				for (int i = 0; i < NSLOT; i++)
					if (tbl[i].state == PS_SLEEPING && tbl[i].chan == r.chan) begin
						tbl[i].state = PS_RUNNABLE;
						if (n < WOKE_MAX) n++;
					end
				o.ok = (n > 0);
				o.woken_count = 7'(n);
			end
			FN_KILL: begin
				k = find_pid(r.pid);
				if (k >= 0) begin
					tbl[k].killed = 1'b1;
					if (tbl[k].state == PS_SLEEPING) tbl[k].state = PS_RUNNABLE;
					o.ok = 1'b1;
				end
			end
			FN_REAP: begin
				k = find_pid(r.pid);
				if (k >= 0 && tbl[k].state == PS_ZOMBIE) begin
					o.ok = 1'b1;
					o.slot_out = 6'(k);
					o.pid_out = tbl[k].pid;
					o.status_out = tbl[k].status;
					o.ready_ticks = tbl[k].ready_cnt;
					o.run_ticks = tbl[k].run_cnt;
					o.sleep_ticks = tbl[k].sleep_cnt;
					tbl[k] = '0;
				end
			end
			FN_TICK: begin
				for (int i = 0; i < NSLOT; i++)
					case (tbl[i].state)
						PS_RUNNABLE: tbl[i].ready_cnt = sat_add(tbl[i].ready_cnt);
						PS_RUNNING: tbl[i].run_cnt = sat_add(tbl[i].run_cnt);
						PS_SLEEPING: tbl[i].sleep_cnt = sat_add(tbl[i].sleep_cnt);
						default: ;
					endcase
				o.ok = 1'b1;
			end
			default: ;
		endcase
		return o;
	endfunction

	// hold valid and payload until the transaction is taken; drop valid
	// only when an idle gap follows
	task automatic send(input req_t r);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		expected_rsp.push_back(table_step(r));
		do @(posedge clk); while (req_stall);
	endtask

	function automatic req_t mk(input func_t f, input logic [5:0] s,
		input logic [15:0] p, input logic [31:0] c, input logic [31:0] x);
		req_t r;
		r.func = f;
		r.slot = s;
		r.pid = p;
		r.chan = c;
		r.exit_code = x;
		return r;
	endfunction

	// directed rows; want_ok is the obvious ok bit, 2 means predictor only
	typedef struct {
		req_t r;
		int want_ok;
	} dir_row_t;

	dir_row_t dir_rows [$];

	initial begin
		dir_rows.push_back('{mk(FN_TICK, 0, 0, 0, 0), 1});
		dir_rows.push_back('{mk(FN_REAP, 0, 16'h0001, 0, 0), 0});
		dir_rows.push_back('{mk(FN_KILL, 0, 16'hFFFF, 0, 0), 0});
		dir_rows.push_back('{mk(FN_RUNNABLE, 6'd63, 0, 0, 0), 0});
		dir_rows.push_back('{mk(FN_WAKEUP, 0, 0, 32'hFFFF_FFFF, 0), 0});
		dir_rows.push_back('{mk(FN_ALLOC, 0, 0, 0, 0), 1});
		dir_rows.push_back('{mk(FN_ALLOC, 0, 0, 0, 0), 1});
		dir_rows.push_back('{mk(FN_ALLOC, 0, 0, 0, 0), 1});
		dir_rows.push_back('{mk(FN_RUNNABLE, 0, 0, 0, 0), 1});
		dir_rows.push_back('{mk(FN_RUNNING, 1, 0, 0, 0), 1});
		dir_rows.push_back('{mk(FN_SLEEP, 2, 0, 32'hFFFF_FFFF, 0), 1});
		dir_rows.push_back('{mk(FN_TICK, 0, 0, 0, 0), 1});
		dir_rows.push_back('{mk(FN_TICK, 0, 0, 0, 0), 1});
		dir_rows.push_back('{mk(FN_WAKEUP, 0, 0, 32'hFFFF_FFFF, 0), 1});
		dir_rows.push_back('{mk(FN_SLEEP, 1, 0, 32'd0, 0), 1});
		dir_rows.push_back('{mk(FN_KILL, 0, 16'd2, 0, 0), 1});
		dir_rows.push_back('{mk(FN_EXIT, 0, 0, 0, 32'h8000_0000), 1});
		dir_rows.push_back('{mk(FN_EXIT, 1, 0, 0, 32'h7FFF_FFFF), 1});
		dir_rows.push_back('{mk(FN_EXIT, 1, 0, 0, 0), 0});
		dir_rows.push_back('{mk(FN_REAP, 0, 16'd3, 0, 0), 0});
		dir_rows.push_back('{mk(FN_REAP, 0, 16'd1, 0, 0), 2});
		dir_rows.push_back('{mk(FN_REAP, 0, 16'd2, 0, 0), 2});
		dir_rows.push_back('{mk(FN_RUNNING, 0, 0, 0, 0), 0});
		dir_rows.push_back('{mk(func_t'(4'd15), 6'd63, 16'hFFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF), 0});
		dir_rows.push_back('{mk(func_t'(4'd9), 0, 0, 0, 0), 0});
	end

	function automatic req_t rand_req();
		req_t r;
		int sel;
		int live_pick;
		r = '0;
		r.slot = 6'($urandom_range(0, 15));
		r.chan = $urandom_range(0, 3);
		r.exit_code = $urandom;
		r.pid = pid_next - 16'($urandom_range(1, 24));
		sel = $urandom_range(0, 99);
		if ($urandom_range(0, 19) == 0) begin
			// noise: full-width fields
			r.slot = 6'($urandom);
			r.pid = 16'($urandom);
			r.chan = $urandom;
		end
		if (sel < 14) r.func = FN_ALLOC;
		else if (sel < 26) r.func = FN_RUNNABLE;
		else if (sel < 38) r.func = FN_RUNNING;
		else if (sel < 48) r.func = FN_SLEEP;
		else if (sel < 56) r.func = FN_WAKEUP;
		else if (sel < 61) r.func = FN_KILL;
		else if (sel < 70) r.func = FN_EXIT;
		else if (sel < 82) r.func = FN_REAP;
		else if (sel < 97) r.func = FN_TICK;
		else r.func = func_t'(4'($urandom_range(9, 15)));
		// three times in four, aim slot and pid at a random entry if it is in use
		live_pick = $urandom_range(0, NSLOT - 1);
		if ($urandom_range(0, 3) != 0 && tbl[live_pick].state != PS_UNUSED) begin
			r.slot = 6'(live_pick);
			r.pid = tbl[live_pick].pid;
		end
		return r;
	endfunction

	// response side: random stall bursts, checked in order
	initial begin
		int burst;
		forever begin
			@(posedge clk);
			if (burst > 0) begin
				burst--;
				rsp_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(0, 4);
				rsp_stall <= 1'b1;
			end else
				rsp_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		rsp_t w;
		cycles <= cycles + 1;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsp.size() == 0) begin
				$display("MISMATCH @%0t unexpected response", $realtime);
				err_count++;
			end else begin
				w = expected_rsp.pop_front();
				if (rsp.ok !== w.ok) report("ok", rsp.ok, w.ok);
				if (rsp.slot_out !== w.slot_out) report("slot_out", rsp.slot_out, w.slot_out);
				if (rsp.pid_out !== w.pid_out) report("pid_out", rsp.pid_out, w.pid_out);
				if (rsp.status_out !== w.status_out)
					report("status_out", rsp.status_out, w.status_out);
				if (rsp.ready_ticks !== w.ready_ticks)
					report("ready_ticks", rsp.ready_ticks, w.ready_ticks);
				if (rsp.run_ticks !== w.run_ticks) report("run_ticks", rsp.run_ticks, w.run_ticks);
				if (rsp.sleep_ticks !== w.sleep_ticks)
					report("sleep_ticks", rsp.sleep_ticks, w.sleep_ticks);
				if (rsp.woken_count !== w.woken_count)
					report("woken_count", rsp.woken_count, w.woken_count);
			end
			rsp_count++;
		end
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		rsp_t w;
		int n_sent;
		for (int i = 0; i < NSLOT; i++) tbl[i] = '0;
		pid_next = 16'd1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			send(dir_rows[i].r);
			w = expected_rsp[$];
			if (dir_rows[i].want_ok != 2 && w.ok != dir_rows[i].want_ok) begin
				$display("MISMATCH directed row %0d: predicted ok %0d, table says %0d",
					i, w.ok, dir_rows[i].want_ok);
				err_count++;
			end
		end

		// fill the table so the full case and table-wide scans are hit
		repeat (NSLOT + 2) send(mk(FN_ALLOC, 0, 0, 0, 0));
		for (int i = 0; i < NSLOT; i += 2) send(mk(FN_SLEEP, 6'(i), 0, 32'd7, 0));
		send(mk(FN_WAKEUP, 0, 0, 32'd7, 0));
		for (int i = 0; i < NSLOT; i++) send(mk(FN_EXIT, 6'(i), 0, 0, 32'(i)));
		for (int i = 0; i < NSLOT; i++) send(mk(FN_REAP, 0, tbl[i].pid, 0, 0));
		n_sent = dir_rows.size() + (NSLOT + 2) + NSLOT / 2 + 1 + 2 * NSLOT;

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i > N_RANDOM - 150) quiet = 1'b1;
			send(rand_req());
		end
		req_valid <= 1'b0;

		while (expected_rsp.size() != 0) @(posedge clk);
		repeat (NSLOT + 10) @(posedge clk);
		$display("Sent %0d directed and fill rows plus %0d random requests", n_sent, N_RANDOM);
		$display("Checked %0d responses against the task-table model", rsp_count);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
